>>> rtl/fps_pkg.sv
// Shared types and constants for the Fitch parsimony site combiner.
// No dependencies; used by every module in rtl/.
package fps_pkg;

	localparam int CODE_W     = 5;
	localparam int GAP_IDX    = 4;
	localparam int WEIGHT_W   = 16;
	localparam int COST_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef logic [CODE_W-1:0]     code_t;
	typedef logic [WEIGHT_W-1:0]   weight_t;
	typedef logic [COST_W-1:0]     cost_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// Register indexes on the configuration port
	localparam cfg_idx_t REG_GAP_RUN_MERGE = cfg_idx_t'(0);
	localparam cfg_idx_t REG_GAP_STRIP     = cfg_idx_t'(1);

	typedef struct packed {
		logic gap_run_merge;
		logic gap_strip;
	} cfg_t;

	// Gap history carried from one site to the next
	typedef struct packed {
		logic prev_left_gap;
		logic prev_right_gap;
		logic prev_parent_gap;
		logic have_prev_site;
	} gap_hist_t;

	typedef struct packed {
		code_t parent_code;
		logic  site_mutation;
		cost_t total_cost;
		logic  is_last;
	} site_res_t;

endpackage

>>> rtl/fitch_parsimony_site_combine.sv
// Top level of the Fitch parsimony site combiner: input register, per-site
// logic, result register. Depends on fps_pkg, fps_cfg_regs, fps_site_eval.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in_valid/in_ready    | left_code, right_code, site_weight, last_site
//   out     | out_valid/out_ready  | parent_code, site_mutation, total_cost, is_last
//
// One site per cycle while out_ready is high; a site goes through the input
// register, then the result register (per-site logic, 32-bit saturating add).
// The cost and gap history update when a site moves into the result register.
// Reset clears both registers' valid bits, the history and the config.
// While out_ready is low the result holds and one more site can wait in the
// input register; cfg_ready is always high.
module fitch_parsimony_site_combine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  fps_pkg::cfg_idx_t  cfg_index,
	input  fps_pkg::cfg_data_t cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  fps_pkg::code_t     left_code,
	input  fps_pkg::code_t     right_code,
	input  fps_pkg::weight_t   site_weight,
	input  logic               last_site,
	output logic               out_valid,
	input  logic               out_ready,
	output fps_pkg::code_t     parent_code,
	output logic               site_mutation,
	output fps_pkg::cost_t     total_cost,
	output logic               is_last
);
	import fps_pkg::*;

	cfg_t      cfg;
	logic      valid_s1;
	code_t     left_s1;
	code_t     right_s1;
	weight_t   weight_s1;
	logic      last_s1;
	logic      valid_s2;
	site_res_t res_s2;
	gap_hist_t hist_q;
	cost_t     cost_q;
	site_res_t res;
	gap_hist_t hist_nxt;
	cost_t     cost_nxt;
	logic      advance;
	logic      in_xfer;

	fps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fps_site_eval u_eval (
		.left_code   (left_s1),
		.right_code  (right_s1),
		.site_weight (weight_s1),
		.last_site   (last_s1),
		.cfg         (cfg),
		.hist        (hist_q),
		.cost        (cost_q),
		.res         (res),
		.hist_nxt    (hist_nxt),
		.cost_nxt    (cost_nxt)
	);

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			left_s1   <= left_code;
			right_s1  <= right_code;
			weight_s1 <= site_weight;
			last_s1   <= last_site;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			hist_q   <= '0;
			cost_q   <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				hist_q <= hist_nxt;
				cost_q <= cost_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign parent_code   = res_s2.parent_code;
	assign site_mutation = res_s2.site_mutation;
	assign total_cost    = res_s2.total_cost;
	assign is_last       = res_s2.is_last;

`ifndef SYNTHESIS
	// a last site leaves the running state cleared
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && last_s1 |=> cost_q == '0 && hist_q == '0)
		else $error("state not cleared after last site");

	// no site since the last clear means no cost
	a_cost_needs_site: assert property (@(posedge clk) disable iff (!arst_n)
		!hist_q.have_prev_site |-> cost_q == '0)
		else $error("cost nonzero with no site seen");

	a_total_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_last |-> total_cost == '0)
		else $error("total_cost nonzero on a non-last site");

	// an empty result register must never hold off the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty result register");
`endif

endmodule

>>> rtl/fps_cfg_regs.sv
// Configuration registers of the site combiner.
// Depends on fps_pkg.
module fps_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  fps_pkg::cfg_idx_t  cfg_index,
	input  fps_pkg::cfg_data_t cfg_data,
	output fps_pkg::cfg_t      cfg
);
	import fps_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Only bit 0 of the data is kept; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_GAP_RUN_MERGE) begin
				cfg_q.gap_run_merge <= cfg_data[0];
			end else if (cfg_index == REG_GAP_STRIP) begin
				cfg_q.gap_strip <= cfg_data[0];
			end
		end
	end

endmodule

>>> rtl/fps_site_eval.sv
// Per-site Fitch step: parent set, mutation decision, saturating cost add
// and the next gap history. Purely combinational. Depends on fps_pkg.
module fps_site_eval (
	input  fps_pkg::code_t     left_code,
	input  fps_pkg::code_t     right_code,
	input  fps_pkg::weight_t   site_weight,
	input  logic               last_site,
	input  fps_pkg::cfg_t      cfg,
	input  fps_pkg::gap_hist_t hist,
	input  fps_pkg::cost_t     cost,
	output fps_pkg::site_res_t res,
	output fps_pkg::gap_hist_t hist_nxt,
	output fps_pkg::cost_t     cost_nxt
);
	import fps_pkg::*;

	code_t             isect;
	code_t             uni;
	code_t             parent;
	logic              mismatch;
	logic              lg;
	logic              rg;
	logic              skip;
	logic              mut;
	logic [COST_W:0]   sum;
	cost_t             cost_sat;
	cost_t             cost_upd;

	always_comb begin
		isect    = left_code & right_code;
		uni      = left_code | right_code;
		mismatch = (isect == '0);
		lg       = left_code[GAP_IDX];
		rg       = right_code[GAP_IDX];

		// gap run continues on a child that was one-sided gapped last site
		skip = mismatch && cfg.gap_run_merge && uni[GAP_IDX] &&
			hist.have_prev_site && hist.prev_parent_gap &&
			((lg && hist.prev_left_gap) || (rg && hist.prev_right_gap)) &&
			(!hist.prev_left_gap || !hist.prev_right_gap);
		mut = mismatch && !skip;

		parent = mismatch ? uni : isect;
		if (!skip && cfg.gap_strip && parent[GAP_IDX] &&
			(parent[GAP_IDX-1:0] != '0)) begin
			parent[GAP_IDX] = 1'b0;
		end

		sum      = {1'b0, cost} + {{(COST_W+1-WEIGHT_W){1'b0}}, site_weight};
		cost_sat = sum[COST_W] ? '1 : sum[COST_W-1:0];
		cost_upd = mut ? cost_sat : cost;

		res.parent_code   = parent;
		res.site_mutation = mut;
		res.total_cost    = last_site ? cost_upd : '0;
		res.is_last       = last_site;

		if (last_site) begin
			hist_nxt = '0;
			cost_nxt = '0;
		end else begin
			hist_nxt.prev_left_gap   = lg;
			hist_nxt.prev_right_gap  = rg;
			hist_nxt.prev_parent_gap = parent[GAP_IDX];
			hist_nxt.have_prev_site  = 1'b1;
			cost_nxt                 = cost_upd;
		end
	end

endmodule
